[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// assertion helper macros for the chunked body decoder
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked on every rising clock edge outside reset
`define HCBD_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("hcbd assertion failed");

// overlapping implication, checked outside reset
`define HCBD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hcbd implication failed");

`endif

[sv/hcbd_pkg.sv]
// ---------------------------------------------------------------------------
// hcbd_pkg
// types, constants and helpers shared by the chunked body decoder
// ---------------------------------------------------------------------------
package hcbd_pkg;

   localparam int SizeWidth = 32;

   localparam logic [SizeWidth-1:0] ChunkZero = '0;
   localparam logic [SizeWidth-1:0] ChunkOne  = {{(SizeWidth-1){1'b0}}, 1'b1};

   localparam logic [31:0] LimitReset = 32'hFFFF_FFFE;

   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharSemi  = 8'h3B;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharTab   = 8'h09;

   typedef enum logic [3:0] {
      PH_SIZE       = 4'd0,
      PH_SIZE_LF    = 4'd1,
      PH_DATA       = 4'd2,
      PH_DATA_CR    = 4'd3,
      PH_DATA_LF    = 4'd4,
      PH_TRAILER    = 4'd5,
      PH_TRAILER_LF = 4'd6,
      PH_DONE       = 4'd7,
      PH_BAD        = 4'd8
   } phase_type;

   typedef enum logic [1:0] {
      ST_INCOMPLETE = 2'd0,
      ST_COMPLETE   = 2'd1,
      ST_INVALID    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        data_valid;
      logic [7:0]  data_byte;
      logic [1:0]  body_status;
      logic        truncated;
      logic [31:0] decoded_length;
      logic        final_result;
   } rsp_type;

   typedef struct packed {
      phase_type            phase;
      logic [SizeWidth-1:0] chunk_remaining;
      logic                 digit_seen;
      logic                 digits_closed;
      logic                 trailer_line_empty;
      logic [31:0]          emitted_count;
      status_type           status;
      logic                 dropped;
   } state_type;

   localparam state_type StateRestart = '{
      phase:              PH_SIZE,
      chunk_remaining:    ChunkZero,
      digit_seen:         1'b0,
      digits_closed:      1'b0,
      trailer_line_empty: 1'b1,
      emitted_count:      32'd0,
      status:             ST_INCOMPLETE,
      dropped:            1'b0
   };

   // bit 4 flags a hex digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

[sv/http_chunked_body_decoder.sv]
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// decodes an http/1.1 chunked body one byte per transaction, one result each
// ---------------------------------------------------------------------------
//  channel  direction  payload              handshake
//  req      in         hcbd_pkg::req_type   req_valid / req_stall
//  rsp      out        hcbd_pkg::rsp_type   rsp_valid / rsp_stall
//  csr      in         32-bit capacity      csr_write_enable, no read-back
//
//  one byte per cycle sustained while rsp_stall is low; a byte goes from req
//  through the input register, then parse logic into the result register
//  the parse state advances when a byte moves into the result register
//  rsp_stall holds the result register; req_stall rises only when both
//  the input register and the result register are full
//  synchronous active-high reset clears control state and sets the
//  capacity to its maximum
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module http_chunked_body_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hcbd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hcbd_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data
);

   logic                in_valid_ff;
   logic                in_valid_in;
   hcbd_pkg::req_type   in_data_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   hcbd_pkg::rsp_type   out_data_ff;
   hcbd_pkg::state_type state_ff;
   hcbd_pkg::state_type state_in;
   hcbd_pkg::rsp_type   step_rsp;
   logic [31:0]         limit_ff;
   logic [31:0]         limit_in;
   logic                out_load;
   logic                in_take;
   logic                status_invalid;
   logic                status_complete;
   logic                phase_bad;
   logic                phase_done;
   logic                phase_data;
   logic                chunk_nonzero;
   logic                length_match;

   hcbd_parse u_parse (
      .state_cur  (state_ff),
      .item       (in_data_ff),
      .emit_limit (limit_ff),
      .state_nxt  (state_in),
      .result     (step_rsp)
   );

   assign out_load  = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign in_take   = req_valid && !req_stall;
   assign req_stall = in_valid_ff && !out_load;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      in_valid_in  = in_take || (in_valid_ff && !out_load);
      out_valid_in = out_load || (out_valid_ff && rsp_stall);
      // capacity zero behaves like one: nothing is emitted
      limit_in     = (csr_write_data == 32'd0) ? 32'd0 : csr_write_data - 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= hcbd_pkg::StateRestart;
         limit_ff     <= hcbd_pkg::LimitReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            limit_ff <= limit_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_data_ff <= req_data;
      end
      if (out_load) begin
         out_data_ff <= step_rsp;
      end
   end

   assign status_invalid  = (state_ff.status == hcbd_pkg::ST_INVALID);
   assign status_complete = (state_ff.status == hcbd_pkg::ST_COMPLETE);
   assign phase_bad       = (state_ff.phase == hcbd_pkg::PH_BAD);
   assign phase_done      = (state_ff.phase == hcbd_pkg::PH_DONE);
   assign phase_data      = (state_ff.phase == hcbd_pkg::PH_DATA);
   assign chunk_nonzero   = (state_ff.chunk_remaining != hcbd_pkg::ChunkZero);
   assign length_match    = (out_data_ff.decoded_length == state_ff.emitted_count);

   `HCBD_ASSERT(a_invalid_iff_bad, clock, reset, status_invalid == phase_bad)
   `HCBD_ASSERT_IMPL(a_complete_done, clock, reset, status_complete, phase_done)
   `HCBD_ASSERT(a_length_tracks, clock, reset, out_load |=> length_match)
   `HCBD_ASSERT_IMPL(a_data_phase_nonzero, clock, reset, phase_data, chunk_nonzero)

endmodule

[sv/hcbd_parse.sv]
// ---------------------------------------------------------------------------
// hcbd_parse
// next-state and result logic for one body byte of a chunked transfer
// ---------------------------------------------------------------------------
module hcbd_parse (
   input  hcbd_pkg::state_type state_cur,
   input  hcbd_pkg::req_type   item,
   input  logic [31:0]         emit_limit,
   output hcbd_pkg::state_type state_nxt,
   output hcbd_pkg::rsp_type   result
);

   hcbd_pkg::state_type s;
   hcbd_pkg::state_type n;
   logic [7:0]          c;
   logic [4:0]          hex;
   logic                emit;

   always_comb begin
      c    = item.body_byte;
      hex  = hcbd_pkg::hex_digit(c);
      s    = item.first_byte ? hcbd_pkg::StateRestart : state_cur;
      n    = s;
      emit = 1'b0;

      unique case (s.phase)
         hcbd_pkg::PH_SIZE: begin
            if (c == hcbd_pkg::CharCr) begin
               n.phase = hcbd_pkg::PH_SIZE_LF;
            end else if (!s.digits_closed) begin
               if (c == hcbd_pkg::CharSemi) begin
                  n.digits_closed = 1'b1;
               end else if (c == hcbd_pkg::CharSpace || c == hcbd_pkg::CharTab) begin
                  if (s.digit_seen) begin
                     n.digits_closed = 1'b1;
                  end
               end else if (!hex[4] ||
                            (s.chunk_remaining[hcbd_pkg::SizeWidth-1 -: 4] != 4'd0)) begin
                  n.phase  = hcbd_pkg::PH_BAD;
                  n.status = hcbd_pkg::ST_INVALID;
               end else begin
                  n.chunk_remaining = {s.chunk_remaining[hcbd_pkg::SizeWidth-5:0], hex[3:0]};
                  n.digit_seen      = 1'b1;
               end
            end
         end
         hcbd_pkg::PH_SIZE_LF: begin
            if (c != hcbd_pkg::CharLf || !s.digit_seen) begin
               n.phase  = hcbd_pkg::PH_BAD;
               n.status = hcbd_pkg::ST_INVALID;
            end else begin
               n.digit_seen    = 1'b0;
               n.digits_closed = 1'b0;
               if (s.chunk_remaining == hcbd_pkg::ChunkZero) begin
                  n.trailer_line_empty = 1'b1;
                  n.phase              = hcbd_pkg::PH_TRAILER;
               end else begin
                  n.phase = hcbd_pkg::PH_DATA;
               end
            end
         end
         hcbd_pkg::PH_DATA: begin
            if (s.emitted_count < emit_limit) begin
               emit            = 1'b1;
               n.emitted_count = s.emitted_count + 32'd1;
            end else begin
               n.dropped = 1'b1;
            end
            n.chunk_remaining = s.chunk_remaining - hcbd_pkg::ChunkOne;
            if (s.chunk_remaining == hcbd_pkg::ChunkOne) begin
               n.phase = hcbd_pkg::PH_DATA_CR;
            end
         end
         hcbd_pkg::PH_DATA_CR: begin
            if (c == hcbd_pkg::CharCr) begin
               n.phase = hcbd_pkg::PH_DATA_LF;
            end else begin
               n.phase  = hcbd_pkg::PH_BAD;
               n.status = hcbd_pkg::ST_INVALID;
            end
         end
         hcbd_pkg::PH_DATA_LF: begin
            if (c == hcbd_pkg::CharLf) begin
               n.phase = hcbd_pkg::PH_SIZE;
            end else begin
               n.phase  = hcbd_pkg::PH_BAD;
               n.status = hcbd_pkg::ST_INVALID;
            end
         end
         hcbd_pkg::PH_TRAILER: begin
            if (c == hcbd_pkg::CharCr) begin
               n.phase = hcbd_pkg::PH_TRAILER_LF;
            end else begin
               n.trailer_line_empty = 1'b0;
            end
         end
         hcbd_pkg::PH_TRAILER_LF: begin
            if (c == hcbd_pkg::CharLf) begin
               if (s.trailer_line_empty) begin
                  n.phase  = hcbd_pkg::PH_DONE;
                  n.status = hcbd_pkg::ST_COMPLETE;
               end else begin
                  n.trailer_line_empty = 1'b1;
                  n.phase              = hcbd_pkg::PH_TRAILER;
               end
            end else begin
               // a lone cr counts as line content
               n.trailer_line_empty = 1'b0;
               if (c != hcbd_pkg::CharCr) begin
                  n.phase = hcbd_pkg::PH_TRAILER;
               end
            end
         end
         hcbd_pkg::PH_DONE: begin
            n = s;
         end
         default: begin
            n.phase  = hcbd_pkg::PH_BAD;
            n.status = hcbd_pkg::ST_INVALID;
         end
      endcase

      state_nxt             = n;
      result.data_valid     = emit;
      result.data_byte      = emit ? c : 8'd0;
      result.body_status    = n.status;
      result.truncated      = n.dropped;
      result.decoded_length = n.emitted_count;
      result.final_result   = item.last_byte;
   end

endmodule

[tb/tb_http_chunked_body_decoder.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// drives chunked bodies byte by byte into the decoder and checks every
// result against a cycle-free model of the parser or a directed row's own
// expected value; a short directed table comes first, then random bodies over
// several capacity settings and idle and stall patterns on both channels
// ---------------------------------------------------------------------------
module tb_http_chunked_body_decoder;

   import hcbd_pkg::*;

   localparam int NumDirected  = 30;
   localparam int NumPhases    = 8;
   localparam int PhaseItems   = 75;
   localparam int HoldCycles   = 300;
   localparam int SettleCycles = 4;
   localparam int CycleLimit   = 200000;

   localparam logic [SizeWidth-1:0] OverflowLimit = {4'h0, {(SizeWidth-4){1'b1}}};

   typedef struct packed {
      logic [7:0] body_byte;
      logic       is_first;
      logic       is_last;
      logic       has_want;
      rsp_type    want;
   } directed_row_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   req_type     req_data         = '0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_enable = 1'b0;
   logic [31:0] csr_write_data   = '0;

   // decoder model state
   phase_type            dec_phase;
   logic [SizeWidth-1:0] dec_remaining;
   logic                 dec_digit_seen;
   logic                 dec_closed;
   logic                 dec_line_empty;
   logic [31:0]          dec_emitted;
   status_type           dec_status;
   logic                 dec_dropped;
   logic [31:0]          dec_capacity;

   rsp_type    result_q[$];
   logic [7:0] body_bytes[$];

   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   logic pressure_on   = 1'b0;
   logic hold_done     = 1'b0;
   int   hold_count    = 0;
   int   error_count   = 0;
   int   cycle_count   = 0;

   directed_row_type directed_table [NumDirected] = '{
      // one-byte chunk closed by a tab, then a bad byte where lf belongs
      '{"1",     1'b1, 1'b0, 1'b1, '{1'b0, 8'h00, ST_INCOMPLETE, 1'b0, 32'd0, 1'b0}},
      '{CharTab, 1'b0, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{CharLf,  1'b0, 1'b0, 1'b0, '0},
      '{8'hFF,   1'b0, 1'b0, 1'b1, '{1'b1, 8'hFF, ST_INCOMPLETE, 1'b0, 32'd1, 1'b0}},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{8'h00,   1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0, 32'd1, 1'b1}},
      // bad character in the size line
      '{"g",     1'b1, 1'b1, 1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0, 32'd0, 1'b1}},
      // size line without any digit
      '{CharCr,  1'b1, 1'b0, 1'b0, '0},
      '{CharLf,  1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0, 32'd0, 1'b1}},
      // cr ends the size line but no lf follows
      '{"a",     1'b1, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0, 32'd0, 1'b0}},
      // size overflows on the ninth digit
      '{"1",     1'b1, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b0, 1'b0, '0},
      '{"0",     1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, ST_INVALID, 1'b0, 32'd0, 1'b1}},
      // zero chunk, a trailer holding only a lone cr, then the empty line
      '{"0",     1'b1, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{CharLf,  1'b0, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{CharLf,  1'b0, 1'b0, 1'b0, '0},
      '{CharCr,  1'b0, 1'b0, 1'b0, '0},
      '{CharLf,  1'b0, 1'b1, 1'b1, '{1'b0, 8'h00, ST_COMPLETE, 1'b0, 32'd0, 1'b1}}
   };

   http_chunked_body_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("tb_http_chunked_body_decoder: FAIL");
         $finish;
      end
   end

   function automatic void restart_decoder();
      dec_phase      = PH_SIZE;
      dec_remaining  = '0;
      dec_digit_seen = 1'b0;
      dec_closed     = 1'b0;
      dec_line_empty = 1'b1;
      dec_emitted    = 32'd0;
      dec_status     = ST_INCOMPLETE;
      dec_dropped    = 1'b0;
   endfunction

   function automatic void mark_invalid();
      dec_phase  = PH_BAD;
      dec_status = ST_INVALID;
   endfunction

   function automatic rsp_type decode_byte(input req_type item);
      rsp_type     res;
      logic [7:0]  c;
      logic [3:0]  nib;
      logic        is_hex;
      logic [31:0] limit;
      c      = item.body_byte;
      res    = '0;
      nib    = 4'd0;
      is_hex = 1'b0;
      if (item.first_byte) restart_decoder();
      case (dec_phase)
         PH_SIZE: begin
            if (c >= 8'h30 && c <= 8'h39) begin
               is_hex = 1'b1;
               nib    = 4'(c - 8'h30);
            end else if (c >= 8'h61 && c <= 8'h66) begin
               is_hex = 1'b1;
               nib    = 4'(c - 8'h57);
            end else if (c >= 8'h41 && c <= 8'h46) begin
               is_hex = 1'b1;
               nib    = 4'(c - 8'h37);
            end
            if (c == CharCr) begin
               dec_phase = PH_SIZE_LF;
            end else if (!dec_closed) begin
               if (c == CharSemi) begin
                  dec_closed = 1'b1;
               end else if (c == CharSpace || c == CharTab) begin
                  // a blank only closes the digits once one was seen
                  dec_closed = dec_digit_seen;
               end else if (!is_hex || dec_remaining > OverflowLimit) begin
                  mark_invalid();
               end else begin
                  dec_remaining  = {dec_remaining[SizeWidth-5:0], nib};
                  dec_digit_seen = 1'b1;
               end
            end
         end
         PH_SIZE_LF: begin
            if (c != CharLf || !dec_digit_seen) begin
               mark_invalid();
            end else begin
               dec_digit_seen = 1'b0;
               dec_closed     = 1'b0;
               if (dec_remaining == '0) begin
                  dec_line_empty = 1'b1;
                  dec_phase      = PH_TRAILER;
               end else begin
                  dec_phase = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            limit = (dec_capacity == 32'd0) ? 32'd0 : dec_capacity - 32'd1;
            if (dec_emitted < limit) begin
               res.data_valid = 1'b1;
               res.data_byte  = c;
               dec_emitted++;
            end else begin
               dec_dropped = 1'b1;
            end
            dec_remaining--;
            if (dec_remaining == '0) dec_phase = PH_DATA_CR;
         end
         PH_DATA_CR: begin
            if (c == CharCr) dec_phase = PH_DATA_LF;
            else mark_invalid();
         end
         PH_DATA_LF: begin
            if (c == CharLf) dec_phase = PH_SIZE;
            else mark_invalid();
         end
         PH_TRAILER: begin
            if (c == CharCr) dec_phase = PH_TRAILER_LF;
            else dec_line_empty = 1'b0;
         end
         PH_TRAILER_LF: begin
            if (c == CharLf) begin
               if (dec_line_empty) begin
                  dec_phase  = PH_DONE;
                  dec_status = ST_COMPLETE;
               end else begin
                  dec_line_empty = 1'b1;
                  dec_phase      = PH_TRAILER;
               end
            end else begin
               // a cr without lf is line content
               dec_line_empty = 1'b0;
               if (c != CharCr) dec_phase = PH_TRAILER;
            end
         end
         PH_DONE: begin
         end
         default: begin
            mark_invalid();
         end
      endcase
      res.body_status    = dec_status;
      res.truncated      = dec_dropped;
      res.decoded_length = dec_emitted;
      res.final_result   = item.last_byte;
      return res;
   endfunction

   function automatic logic [7:0] hex_char(input int unsigned nib);
      if (nib < 10) return 8'h30 + 8'(nib);
      return 8'(nib - 10) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
   endfunction

   function automatic logic [7:0] non_cr_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CharCr);
      return b;
   endfunction

   function automatic void push_crlf();
      body_bytes.push_back(CharCr);
      body_bytes.push_back(CharLf);
   endfunction

   function automatic void push_size_line(input int unsigned size);
      int top;
      int suffix;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
         body_bytes.push_back($urandom_range(0, 1) ? CharSpace : CharTab);
      if ($urandom_range(0, 3) == 0) body_bytes.push_back(8'h30);
      top = 7;
      while (top > 0 && ((size >> (4 * top)) & 15) == 0) top--;
      for (int i = top; i >= 0; i--) body_bytes.push_back(hex_char((size >> (4 * i)) & 15));
      suffix = $urandom_range(0, 7);
      if (suffix < 2) begin
         // blank after the digits, then junk up to the line end
         body_bytes.push_back(suffix == 0 ? CharSpace : CharTab);
         repeat ($urandom_range(0, 3)) body_bytes.push_back(non_cr_byte());
      end else if (suffix < 4) begin
         body_bytes.push_back(CharSemi);
         repeat ($urandom_range(0, 5)) body_bytes.push_back(non_cr_byte());
      end
      push_crlf();
   endfunction

   function automatic void build_body();
      int         kind;
      int         size;
      logic [7:0] b;
      body_bytes.delete();
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         repeat ($urandom_range(1, 12)) body_bytes.push_back(8'($urandom_range(0, 255)));
         return;
      end
      if (kind < 12) begin
         // chunk size too wide for the counter
         body_bytes.push_back(hex_char($urandom_range(1, 15)));
         repeat ($urandom_range(8, 9)) body_bytes.push_back(hex_char($urandom_range(0, 15)));
         push_crlf();
         return;
      end
      repeat ($urandom_range(0, 3)) begin
         size = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
         push_size_line(size);
         repeat (size) body_bytes.push_back(8'($urandom_range(0, 255)));
         push_crlf();
      end
      push_size_line(0);
      repeat ($urandom_range(0, 2)) begin
         repeat ($urandom_range(1, 6)) body_bytes.push_back(non_cr_byte());
         if ($urandom_range(0, 3) == 0) begin
            body_bytes.push_back(CharCr);
            do b = 8'($urandom_range(0, 255)); while (b == CharCr || b == CharLf);
            body_bytes.push_back(b);
         end
         push_crlf();
      end
      push_crlf();
      if (kind >= 85)
         body_bytes[$urandom_range(0, body_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_item(input req_type item, input logic has_want, input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = decode_byte(item);
      result_q.push_back(has_want ? want : predicted);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dec_capacity = value;
   endtask

   // result side: check each accepted transaction, then pick the next stall
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (result_q.size() == 0) begin
               $error("unexpected result transaction: %h", rsp_data);
               error_count++;
            end else begin
               want = result_q.pop_front();
               if (rsp_data.data_valid !== want.data_valid) begin
                  $error("data_valid: expected %0d, actual %0d",
                         want.data_valid, rsp_data.data_valid);
                  error_count++;
               end
               if (rsp_data.data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, actual %0h",
                         want.data_byte, rsp_data.data_byte);
                  error_count++;
               end
               if (rsp_data.body_status !== want.body_status) begin
                  $error("body_status: expected %0d, actual %0d",
                         want.body_status, rsp_data.body_status);
                  error_count++;
               end
               if (rsp_data.truncated !== want.truncated) begin
                  $error("truncated: expected %0d, actual %0d",
                         want.truncated, rsp_data.truncated);
                  error_count++;
               end
               if (rsp_data.decoded_length !== want.decoded_length) begin
                  $error("decoded_length: expected %0d, actual %0d",
                         want.decoded_length, rsp_data.decoded_length);
                  error_count++;
               end
               if (rsp_data.final_result !== want.final_result) begin
                  $error("final_result: expected %0d, actual %0d",
                         want.final_result, rsp_data.final_result);
                  error_count++;
               end
            end
         end
         if (pressure_on && !hold_done) begin
            // long hold-off so the decoder fills up and stalls its input
            hold_count++;
            if (hold_count >= HoldCycles) hold_done = 1'b1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin
      req_type     item;
      logic [31:0] capacity;
      logic        restart_body;
      int          sent;
      dec_capacity = 32'hFFFF_FFFF;
      restart_decoder();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) begin
         item.body_byte  = directed_table[i].body_byte;
         item.first_byte = directed_table[i].is_first;
         item.last_byte  = directed_table[i].is_last;
         send_item(item, directed_table[i].has_want, directed_table[i].want);
      end

      for (int phase = 0; phase < NumPhases; phase++) begin
         drain();
         pressure_on = 1'b0;
         case (phase)
            0: begin capacity = 32'hFFFF_FFFF; send_idle_pct = 0;  stall_pct = 0;  end
            1: begin capacity = 32'd0;         send_idle_pct = 59; stall_pct = 0;  end
            2: begin capacity = 32'd1;         send_idle_pct = 0;  stall_pct = 59; end
            3: begin capacity = 32'd2;         send_idle_pct = 35; stall_pct = 35; end
            4: begin capacity = $urandom_range(3, 40); send_idle_pct = 59; stall_pct = 0; end
            5: begin
               capacity      = 32'hFFFF_FFFF;
               send_idle_pct = 0;
               stall_pct     = 0;
               pressure_on   = 1'b1;
            end
            6: begin capacity = $urandom_range(5, 120); send_idle_pct = 35; stall_pct = 35; end
            default: begin
               capacity = $urandom_range(3, 30); send_idle_pct = 0; stall_pct = 59;
            end
         endcase
         write_capacity(capacity);
         sent = 0;
         while (sent < PhaseItems) begin
            build_body();
            restart_body = ($urandom_range(0, 9) != 0);
            foreach (body_bytes[i]) begin
               item.body_byte  = body_bytes[i];
               item.first_byte = (i == 0) && restart_body;
               item.last_byte  = (i == body_bytes.size() - 1) || ($urandom_range(0, 31) == 0);
               // bytes after complete or invalid are ignored by the parser
               if (item.first_byte || !(dec_phase inside {PH_DONE, PH_BAD})) sent++;
               send_item(item, 1'b0, '0);
            end
         end
      end

      drain();
      if (error_count == 0) begin
         $display("tb_http_chunked_body_decoder: PASS");
      end else begin
         $display("tb_http_chunked_body_decoder: FAIL");
      end
      $finish;
   end

endmodule
